// ----- rtl/core/ocpg_pkg.sv -----
// ----------------------------------------------------------------------------
// ocpg_pkg
// shared codes and constants of the display command parser and frame memory
// ----------------------------------------------------------------------------
package ocpg_pkg;

    localparam int COLUMNS = 128;
    localparam int OFF_W   = 16;

    // parser phase
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ONE  = 2'd1;
    localparam logic [1:0] PH_TWO  = 2'd2;

    // pending command
    localparam logic [1:0] PC_NONE    = 2'd0;
    localparam logic [1:0] PC_MODE    = 2'd1;
    localparam logic [1:0] PC_COLWIN  = 2'd2;
    localparam logic [1:0] PC_PAGEWIN = 2'd3;

    // addressing modes
    localparam logic [2:0] AM_HORZ = 3'd0;
    localparam logic [2:0] AM_VERT = 3'd1;
    localparam logic [2:0] AM_PAGE = 3'd2;

    // command bytes and masks
    localparam logic [7:0] CMD_MODE     = 8'h20;
    localparam logic [7:0] CMD_COLWIN   = 8'h21;
    localparam logic [7:0] CMD_PAGEWIN  = 8'h22;
    localparam logic [7:0] CMD_ENTIRE   = 8'hA4;
    localparam logic [7:0] CMD_INVERSE  = 8'hA6;
    localparam logic [7:0] CMD_DISPLAY  = 8'hAE;
    localparam logic [7:0] CMD_PAGE     = 8'hB0;
    localparam logic [7:0] CMD_COL_LO   = 8'h00;
    localparam logic [7:0] CMD_COL_HI   = 8'h10;
    localparam logic [7:0] MASK_HI_NIB  = 8'hF0;
    localparam logic [7:0] MASK_FLAG    = 8'hFE;
    localparam logic [7:0] MASK_PAGE    = 8'hF8;

    localparam logic [6:0] COL_STOP_RST  = 7'd127;
    localparam logic [6:0] PAGE_STOP_RST = 7'd7;

endpackage

// ----- rtl/core/oled_command_parser_gddram.sv -----
// ----------------------------------------------------------------------------
// oled_command_parser_gddram
// display controller command decoder with column/page addressed frame memory
// ----------------------------------------------------------------------------
// Takes one word per cycle unless clearing or held by the output: a bus write
// (command or data byte, used only while chip-selected) or a scan read of one
// memory column, and returns one result word per input word, registered in
// stage 1 and then the output register. The frame memory is one single-port RAM
// of 128*PAGES bytes with registered read data; writes land at the edge of
// acceptance, so a scan of the very next word sees them. After reset the RAM is
// cleared one byte per cycle, and no word is accepted until it is all cleared.
module oled_command_parser_gddram #(
    parameter int PAGES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // chip_selected[0], bus_byte[8:1], scan_offset[17:9], zero fill above
    input  logic [23:0] s_axis_tdata,
    // func[0], is_data[1]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // accepted[0], pixel_bits[8:1], zero fill above
    output logic [15:0] m_axis_tdata
);

    localparam int MEM_BYTES = ocpg_pkg::COLUMNS * PAGES;
    localparam int AW        = $clog2(MEM_BYTES);
    localparam int OW        = ocpg_pkg::OFF_W;

    logic [7:0] r_mem [MEM_BYTES];
    logic [7:0] r_rd_data;

    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    logic [1:0] r_phase,     n_phase;
    logic [1:0] r_pend,      n_pend;
    logic [7:0] r_first_arg, n_first_arg;
    logic       r_disp_on,   n_disp_on;
    logic       r_entire_on, n_entire_on;
    logic       r_inv_on,    n_inv_on;
    logic [2:0] r_mode,      n_mode;
    logic [6:0] r_col_start, n_col_start;
    logic [6:0] r_col_stop,  n_col_stop;
    logic [6:0] r_pg_start,  n_pg_start;
    logic [6:0] r_pg_stop,   n_pg_stop;
    logic [7:0] r_col_ptr,   n_col_ptr;
    logic [6:0] r_pg_ptr,    n_pg_ptr;
    logic       n_accepted;

    logic       r_s1_valid;
    logic       r_s1_scan;
    logic       r_s1_acc;
    logic       r_s1_disp;
    logic       r_s1_entire;
    logic       r_s1_inv;

    logic       r_out_valid;
    logic       r_out_acc;
    logic [7:0] r_out_pix;

    logic          in_fire;
    logic          s1_adv;
    logic          in_func;
    logic          in_cs;
    logic          in_is_data;
    logic [7:0]    in_byte;
    logic [8:0]    in_soff;
    logic [OW-1:0] wr_off;
    logic [OW-1:0] rd_off;
    logic [AW-1:0] wr_idx;
    logic [AW-1:0] rd_idx;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [7:0]    mem_wd;
    logic          mem_re;
    logic [7:0]    col_inc;
    logic [6:0]    pg_inc;
    logic          col_over;
    logic          pg_over;
    logic [7:0]    s1_pix;

    assign in_func    = s_axis_tuser[0];
    assign in_is_data = s_axis_tuser[1];
    assign in_cs      = s_axis_tdata[0];
    assign in_byte    = s_axis_tdata[8:1];
    assign in_soff    = s_axis_tdata[17:9];

    assign s1_adv        = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_clr_busy && (!r_s1_valid || s1_adv);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // memory offsets, out of range maps to zero
    assign wr_off = OW'({r_pg_ptr, 7'd0}) + OW'(r_col_ptr);
    assign rd_off = OW'(in_soff);
    assign wr_idx = (wr_off < OW'(MEM_BYTES)) ? wr_off[AW-1:0] : '0;
    assign rd_idx = (rd_off < OW'(MEM_BYTES)) ? rd_off[AW-1:0] : '0;

    assign mem_we = r_clr_busy || (in_fire && !in_func && in_cs && in_is_data);
    assign mem_wa = r_clr_busy ? r_clr_addr : wr_idx;
    assign mem_wd = r_clr_busy ? 8'd0 : in_byte;
    assign mem_re = in_fire && in_func;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(MEM_BYTES - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    assign col_inc  = r_col_ptr + 8'd1;
    assign pg_inc   = r_pg_ptr + 7'd1;
    assign col_over = col_inc > {1'b0, r_col_stop};
    assign pg_over  = pg_inc > r_pg_stop;

    always_comb begin
        n_phase     = r_phase;
        n_pend      = r_pend;
        n_first_arg = r_first_arg;
        n_disp_on   = r_disp_on;
        n_entire_on = r_entire_on;
        n_inv_on    = r_inv_on;
        n_mode      = r_mode;
        n_col_start = r_col_start;
        n_col_stop  = r_col_stop;
        n_pg_start  = r_pg_start;
        n_pg_stop   = r_pg_stop;
        n_col_ptr   = r_col_ptr;
        n_pg_ptr    = r_pg_ptr;
        n_accepted  = 1'b0;
        if (!in_func && in_cs) begin
            if (in_is_data) begin
                n_accepted = 1'b1;
                unique case (r_mode)
                    ocpg_pkg::AM_PAGE: begin
                        n_col_ptr = col_over ? {1'b0, r_col_start} : col_inc;
                    end
                    ocpg_pkg::AM_HORZ: begin
                        if (col_over) begin
                            n_col_ptr = {1'b0, r_col_start};
                            n_pg_ptr  = pg_over ? r_pg_start : pg_inc;
                        end else begin
                            n_col_ptr = col_inc;
                        end
                    end
                    ocpg_pkg::AM_VERT: begin
                        if (pg_over) begin
                            n_pg_ptr  = r_pg_start;
                            n_col_ptr = col_over ? {1'b0, r_col_start} : col_inc;
                        end else begin
                            n_pg_ptr = pg_inc;
                        end
                    end
                    default: begin
                    end
                endcase
            end else if (r_phase == ocpg_pkg::PH_TWO) begin
                n_first_arg = in_byte;
                n_phase     = ocpg_pkg::PH_ONE;
            end else if (r_phase == ocpg_pkg::PH_ONE) begin
                n_phase = ocpg_pkg::PH_IDLE;
                unique case (r_pend)
                    ocpg_pkg::PC_MODE: begin
                        n_mode     = in_byte[2:0];
                        n_accepted = 1'b1;
                    end
                    ocpg_pkg::PC_COLWIN: begin
                        n_col_start = r_first_arg[6:0];
                        n_col_stop  = in_byte[6:0];
                        n_col_ptr   = {1'b0, r_first_arg[6:0]};
                        n_accepted  = 1'b1;
                    end
                    ocpg_pkg::PC_PAGEWIN: begin
                        n_pg_start = r_first_arg[6:0];
                        n_pg_stop  = in_byte[6:0];
                        n_pg_ptr   = r_first_arg[6:0];
                        n_accepted = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end else begin
                n_phase = ocpg_pkg::PH_IDLE;
                priority if ((in_byte & ocpg_pkg::MASK_HI_NIB) == ocpg_pkg::CMD_MODE) begin
                    if (in_byte == ocpg_pkg::CMD_MODE) begin
                        n_phase = ocpg_pkg::PH_ONE;
                        n_pend  = ocpg_pkg::PC_MODE;
                    end else if (in_byte == ocpg_pkg::CMD_COLWIN) begin
                        n_phase = ocpg_pkg::PH_TWO;
                        n_pend  = ocpg_pkg::PC_COLWIN;
                    end else if (in_byte == ocpg_pkg::CMD_PAGEWIN) begin
                        n_phase = ocpg_pkg::PH_TWO;
                        n_pend  = ocpg_pkg::PC_PAGEWIN;
                    end
                end else if ((in_byte & ocpg_pkg::MASK_FLAG) == ocpg_pkg::CMD_ENTIRE) begin
                    n_entire_on = in_byte[0];
                    n_accepted  = 1'b1;
                end else if ((in_byte & ocpg_pkg::MASK_FLAG) == ocpg_pkg::CMD_INVERSE) begin
                    n_inv_on   = in_byte[0];
                    n_accepted = 1'b1;
                end else if ((in_byte & ocpg_pkg::MASK_FLAG) == ocpg_pkg::CMD_DISPLAY) begin
                    n_disp_on  = in_byte[0];
                    n_accepted = 1'b1;
                end else if ((in_byte & ocpg_pkg::MASK_PAGE) == ocpg_pkg::CMD_PAGE) begin
                    n_pg_ptr   = {5'd0, in_byte[1:0]};
                    n_accepted = 1'b1;
                end else if ((in_byte & ocpg_pkg::MASK_HI_NIB) == ocpg_pkg::CMD_COL_LO) begin
                    n_col_ptr  = {r_col_ptr[7:4], in_byte[3:0]};
                    n_accepted = 1'b1;
                end else if ((in_byte & ocpg_pkg::MASK_HI_NIB) == ocpg_pkg::CMD_COL_HI) begin
                    n_col_ptr  = {in_byte[3:0], r_col_ptr[3:0]};
                    n_accepted = 1'b1;
                end else begin
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= ocpg_pkg::PH_IDLE;
            r_pend      <= ocpg_pkg::PC_NONE;
            r_first_arg <= 8'd0;
            r_disp_on   <= 1'b0;
            r_entire_on <= 1'b0;
            r_inv_on    <= 1'b0;
            r_mode      <= ocpg_pkg::AM_PAGE;
            r_col_start <= 7'd0;
            r_col_stop  <= ocpg_pkg::COL_STOP_RST;
            r_pg_start  <= 7'd0;
            r_pg_stop   <= ocpg_pkg::PAGE_STOP_RST;
            r_col_ptr   <= 8'd0;
            r_pg_ptr    <= 7'd0;
        end else if (in_fire) begin
            r_phase     <= n_phase;
            r_pend      <= n_pend;
            r_first_arg <= n_first_arg;
            r_disp_on   <= n_disp_on;
            r_entire_on <= n_entire_on;
            r_inv_on    <= n_inv_on;
            r_mode      <= n_mode;
            r_col_start <= n_col_start;
            r_col_stop  <= n_col_stop;
            r_pg_start  <= n_pg_start;
            r_pg_stop   <= n_pg_stop;
            r_col_ptr   <= n_col_ptr;
            r_pg_ptr    <= n_pg_ptr;
        end
    end

    // stage 1: waits for memory read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_scan   <= in_func;
            r_s1_acc    <= n_accepted;
            r_s1_disp   <= r_disp_on;
            r_s1_entire <= r_entire_on;
            r_s1_inv    <= r_inv_on;
        end
    end

    always_comb begin
        s1_pix = 8'd0;
        if (r_s1_scan && r_s1_disp) begin
            if (r_s1_entire) begin
                s1_pix = 8'hFF;
            end else begin
                s1_pix = r_s1_inv ? ~r_rd_data : r_rd_data;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_out_acc <= r_s1_acc;
            r_out_pix <= s1_pix;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_pix, r_out_acc};

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// stream-level check of the display command parser and its frame memory
// ----------------------------------------------------------------------------
// A queue of bus writes and scan reads is built up front: a directed opener
// covering flags, windows, nibble commands, out-of-range offsets, unknown
// bytes and data inside a pending command, then random command sequences,
// data bursts, scans and noise. A clocked driver feeds the queue to the slave
// side with random gaps. A shadow of the parser, pointers and frame memory
// predicts each result at acceptance; the monitor compares every result word
// with the oldest prediction. The receiver stalls at random, once for a long
// stretch so the block backs up into its input.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAGES       = 4;
    localparam int MEM_BYTES   = ocpg_pkg::COLUMNS * PAGES;
    localparam int ITEMS       = 1350;
    localparam int STALL_LIMIT = 4000;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_WAIT  = 20;

    typedef struct {
        bit          fn;
        bit          cs;
        bit          dat;
        bit [7:0]    b;
        bit [8:0]    soff;
        int unsigned gap;
    } t_bus_word;

    typedef struct {
        bit       acc;
        bit [7:0] pix;
    } t_pixel_word;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;   // chip_selected, bus_byte, scan_offset, zero fill
    logic [1:0]  s_axis_tuser  = '0;   // func, is_data
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // accepted, pixel_bits, zero fill

    oled_command_parser_gddram #(.PAGES(PAGES)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // shadow of the block state
    bit [7:0]    gram [MEM_BYTES];
    bit [1:0]    phase       = ocpg_pkg::PH_IDLE;
    bit [1:0]    pend_cmd    = ocpg_pkg::PC_NONE;
    bit [7:0]    first_arg   = '0;
    bit          disp_on     = 1'b0;
    bit          ent_on      = 1'b0;
    bit          inv_on      = 1'b0;
    bit [2:0]    am          = ocpg_pkg::AM_PAGE;
    bit [6:0]    col_start   = '0;
    bit [6:0]    col_stop    = ocpg_pkg::COL_STOP_RST;
    bit [6:0]    page_start  = '0;
    bit [6:0]    page_stop   = ocpg_pkg::PAGE_STOP_RST;
    bit [7:0]    col_ptr     = '0;
    bit [6:0]    pg_ptr      = '0;

    t_bus_word   word_q[$];
    t_pixel_word pixel_q[$];
    int unsigned n_put       = 0;
    bit          tx_calm     = 1'b0;
    int unsigned n_fail      = 0;
    logic        in_fire     = 1'b0;
    logic        out_fire    = 1'b0;
    int unsigned stall_cycles = 0;

    function automatic int unsigned mem_slot(int unsigned o);
        return (o < MEM_BYTES) ? o : 0;
    endfunction

    function automatic void step_pointers();
        bit [7:0] c;
        bit [6:0] p;
        c = col_ptr + 8'd1;
        p = pg_ptr + 7'd1;
        case (am)
            ocpg_pkg::AM_PAGE: begin
                col_ptr = (c > col_stop) ? {1'b0, col_start} : c;
            end
            ocpg_pkg::AM_HORZ: begin
                if (c > col_stop) begin
                    col_ptr = {1'b0, col_start};
                    pg_ptr  = (p > page_stop) ? page_start : p;
                end else begin
                    col_ptr = c;
                end
            end
            ocpg_pkg::AM_VERT: begin
                if (p > page_stop) begin
                    pg_ptr  = page_start;
                    col_ptr = (c > col_stop) ? {1'b0, col_start} : c;
                end else begin
                    pg_ptr = p;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic bit parse_command(bit [7:0] d);
        bit done;
        done = 1'b1;
        if (phase == ocpg_pkg::PH_TWO) begin
            first_arg = d;
            phase     = ocpg_pkg::PH_ONE;
            return 1'b0;
        end
        if (phase == ocpg_pkg::PH_ONE) begin
            case (pend_cmd)
                ocpg_pkg::PC_MODE: am = d[2:0];
                ocpg_pkg::PC_COLWIN: begin
                    col_start = first_arg[6:0];
                    col_stop  = d[6:0];
                    col_ptr   = {1'b0, col_start};
                end
                ocpg_pkg::PC_PAGEWIN: begin
                    page_start = first_arg[6:0];
                    page_stop  = d[6:0];
                    pg_ptr     = page_start;
                end
                default: done = 1'b0;
            endcase
            phase = ocpg_pkg::PH_IDLE;
            return done;
        end
        phase = ocpg_pkg::PH_IDLE;
        if ((d & ocpg_pkg::MASK_HI_NIB) == ocpg_pkg::CMD_MODE) begin
            if (d == ocpg_pkg::CMD_MODE) begin
                phase    = ocpg_pkg::PH_ONE;
                pend_cmd = ocpg_pkg::PC_MODE;
            end else if (d == ocpg_pkg::CMD_COLWIN) begin
                phase    = ocpg_pkg::PH_TWO;
                pend_cmd = ocpg_pkg::PC_COLWIN;
            end else if (d == ocpg_pkg::CMD_PAGEWIN) begin
                phase    = ocpg_pkg::PH_TWO;
                pend_cmd = ocpg_pkg::PC_PAGEWIN;
            end
            return 1'b0;
        end
        if ((d & ocpg_pkg::MASK_FLAG) == ocpg_pkg::CMD_ENTIRE) begin
            ent_on = d[0];
            return 1'b1;
        end
        if ((d & ocpg_pkg::MASK_FLAG) == ocpg_pkg::CMD_INVERSE) begin
            inv_on = d[0];
            return 1'b1;
        end
        if ((d & ocpg_pkg::MASK_FLAG) == ocpg_pkg::CMD_DISPLAY) begin
            disp_on = d[0];
            return 1'b1;
        end
        if ((d & ocpg_pkg::MASK_PAGE) == ocpg_pkg::CMD_PAGE) begin
            pg_ptr = {5'd0, d[1:0]};
            return 1'b1;
        end
        if ((d & ocpg_pkg::MASK_HI_NIB) == ocpg_pkg::CMD_COL_LO) begin
            col_ptr[3:0] = d[3:0];
            return 1'b1;
        end
        if ((d & ocpg_pkg::MASK_HI_NIB) == ocpg_pkg::CMD_COL_HI) begin
            col_ptr[7:4] = d[3:0];
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_pixel_word predict_word(bit fn, bit cs, bit dat, bit [7:0] b,
                                                 bit [8:0] soff);
        t_pixel_word r;
        bit [7:0]    rd_byte;
        int unsigned o;
        r.acc = 1'b0;
        r.pix = '0;
        if (fn) begin
            rd_byte = gram[mem_slot(soff)];
            if (disp_on)
                r.pix = ent_on ? 8'hFF : (inv_on ? ~rd_byte : rd_byte);
        end else if (cs) begin
            if (dat) begin
                o = pg_ptr * ocpg_pkg::COLUMNS + col_ptr;
                gram[mem_slot(o)] = b;
                step_pointers();
                r.acc = 1'b1;
            end else begin
                r.acc = parse_command(b);
            end
        end
        return r;
    endfunction

    task automatic put(bit fn, bit cs, bit dat, bit [7:0] b, bit [8:0] soff);
        t_bus_word w;
        w.fn   = fn;
        w.cs   = cs;
        w.dat  = dat;
        w.b    = b;
        w.soff = soff;
        w.gap  = tx_calm ? 0 : $urandom_range(0, 11);
        word_q.push_back(w);
        n_put++;
        if (n_put % 90 == 0)
            tx_calm = !tx_calm;
    endtask

    task automatic cmd(bit [7:0] b);
        put(1'b0, 1'b1, 1'b0, b, 9'($urandom));
    endtask

    task automatic data(bit [7:0] b);
        put(1'b0, 1'b1, 1'b1, b, 9'($urandom));
    endtask

    task automatic scan(bit [8:0] soff);
        put(1'b1, 1'($urandom), 1'($urandom), 8'($urandom), soff);
    endtask

    // driver
    t_bus_word   drv_w;
    bit          drv_armed = 1'b0;
    int unsigned drv_wait  = 0;

    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || in_fire)) begin
            if (word_q.size() == 0) begin
                s_axis_tvalid <= 1'b0;
            end else begin
                if (!drv_armed) begin
                    drv_wait  = word_q[0].gap;
                    drv_armed = 1'b1;
                end
                if (drv_wait != 0) begin
                    drv_wait--;
                    s_axis_tvalid <= 1'b0;
                end else begin
                    drv_w     = word_q.pop_front();
                    drv_armed = 1'b0;
                    s_axis_tdata  <= {6'd0, drv_w.soff, drv_w.b, drv_w.cs};
                    s_axis_tuser  <= {drv_w.dat, drv_w.fn};
                    s_axis_tvalid <= 1'b1;
                end
            end
        end
    end

    // receiver
    int unsigned rx_seen = 0;
    int unsigned rx_hold = 0;
    bit          rx_calm = 1'b0;

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (out_fire) begin
                rx_seen++;
                if (rx_seen == 400)
                    rx_hold = LONG_HOLD;
                else
                    rx_hold = rx_calm ? 0 : $urandom_range(0, 11);
                if (rx_seen % 80 == 0)
                    rx_calm = !rx_calm;
            end
            if (rx_hold != 0) begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // monitor and predictor
    always @(posedge i_clk) begin
        t_pixel_word got;
        t_pixel_word want;
        in_fire  <= s_axis_tvalid && s_axis_tready;
        out_fire <= m_axis_tvalid && m_axis_tready;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.acc = m_axis_tdata[0];
            got.pix = m_axis_tdata[8:1];
            if (pixel_q.size() == 0) begin
                $error("result word with nothing pending: accepted %0d pixel_bits %02h",
                       got.acc, got.pix);
                n_fail++;
            end else begin
                want = pixel_q.pop_front();
                if (got.acc !== want.acc) begin
                    $error("accepted: expected %0d, got %0d", want.acc, got.acc);
                    n_fail++;
                end
                if (got.pix !== want.pix) begin
                    $error("pixel_bits: expected %02h, got %02h", want.pix, got.pix);
                    n_fail++;
                end
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            pixel_q.push_back(predict_word(s_axis_tuser[0], s_axis_tdata[0], s_axis_tuser[1],
                                           s_axis_tdata[8:1], s_axis_tdata[17:9]));
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int unsigned k;
        bit [7:0]    lo;
        bit [7:0]    hi;
        bit [7:0]    arg;

        // directed opener
        scan(9'd0);
        cmd(ocpg_pkg::CMD_DISPLAY | 8'h01);
        data(8'hFF);
        data(8'h5A);
        put(1'b0, 1'b0, 1'b0, ocpg_pkg::CMD_DISPLAY, 9'h1FF);
        scan(9'd1);
        cmd(ocpg_pkg::CMD_INVERSE | 8'h01);
        scan(9'd1);
        cmd(ocpg_pkg::CMD_ENTIRE | 8'h01);
        scan(9'd511);
        cmd(ocpg_pkg::CMD_ENTIRE);
        cmd(ocpg_pkg::CMD_INVERSE);
        cmd(ocpg_pkg::CMD_COLWIN);
        cmd(8'hFF);
        cmd(8'h80);
        cmd(ocpg_pkg::CMD_PAGE | 8'h07);
        cmd(ocpg_pkg::CMD_COL_HI | 8'h0F);
        cmd(ocpg_pkg::CMD_COL_LO | 8'h0F);
        data(8'hC3);                   // lands beyond memory, stored at offset zero
        scan(9'd0);
        cmd(8'h2F);
        cmd(ocpg_pkg::CMD_MODE);
        data(8'h11);                   // data while the mode argument is pending
        cmd(8'h05);
        data(8'h22);

        // random sequences
        while (n_put < ITEMS) begin
            k = $urandom_range(0, 99);
            if (k < 30) begin
                repeat ($urandom_range(1, 8)) data(8'($urandom));
            end else if (k < 45) begin
                repeat ($urandom_range(1, 4)) scan(9'($urandom_range(0, MEM_BYTES - 1)));
            end else if (k < 52) begin
                arg = 8'($urandom);
                if (arg[2:0] > 3'd2 && $urandom_range(0, 3) != 0)
                    arg[2:0] = 3'($urandom_range(0, 2));
                cmd(ocpg_pkg::CMD_MODE);
                cmd(arg);
            end else if (k < 60) begin
                lo = 8'($urandom_range(0, 127));
                if ($urandom_range(0, 1) == 0)
                    hi = 8'($urandom_range(lo, (lo + 7 > 127) ? 127 : lo + 7));
                else
                    hi = 8'($urandom_range(0, 127));
                lo[7] = 1'($urandom);
                hi[7] = 1'($urandom);
                cmd(ocpg_pkg::CMD_COLWIN);
                cmd(lo);
                cmd(hi);
            end else if (k < 67) begin
                if ($urandom_range(0, 4) == 0) begin
                    lo = 8'($urandom);
                    hi = 8'($urandom);
                end else begin
                    lo = 8'($urandom_range(0, PAGES - 1));
                    hi = 8'($urandom_range(lo, PAGES - 1));
                end
                cmd(ocpg_pkg::CMD_PAGEWIN);
                cmd(lo);
                cmd(hi);
            end else if (k < 75) begin
                case ($urandom_range(0, 2))
                    0: cmd(ocpg_pkg::CMD_ENTIRE | 8'($urandom_range(0, 3) == 0));
                    1: cmd(ocpg_pkg::CMD_INVERSE | 8'($urandom_range(0, 1)));
                    default: cmd(ocpg_pkg::CMD_DISPLAY | 8'($urandom_range(0, 3) != 0));
                endcase
            end else if (k < 80) begin
                cmd(ocpg_pkg::CMD_PAGE | 8'($urandom_range(0, 7)));
            end else if (k < 86) begin
                cmd(ocpg_pkg::CMD_COL_LO | 8'($urandom_range(0, 15)));
                cmd(ocpg_pkg::CMD_COL_HI | 8'($urandom_range(0, 15)));
            end else if (k < 91) begin
                // interrupted window sequences
                cmd(($urandom_range(0, 1) == 0) ? ocpg_pkg::CMD_COLWIN
                                                : ocpg_pkg::CMD_PAGEWIN);
                if ($urandom_range(0, 1) == 0)
                    cmd(8'($urandom));
                data(8'($urandom));
                scan(9'($urandom));
            end else if (k < 96) begin
                put(1'b0, 1'b0, 1'($urandom), 8'($urandom), 9'($urandom));
            end else begin
                put(1'($urandom), 1'($urandom), 1'($urandom), 8'($urandom), 9'($urandom));
            end
        end

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (word_q.size() != 0 || s_axis_tvalid)
            @(negedge i_clk);
        while (pixel_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        if (n_fail == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/ocpg_pkg.sv
rtl/core/oled_command_parser_gddram.sv
sim/tb_top.sv
